// File: rtl/lfu_cache_with_lru_tiebreak_macros.svh
// Assertion macros for the LFU cache checker
`ifndef LFU_CACHE_WITH_LRU_TIEBREAK_MACROS_SVH
`define LFU_CACHE_WITH_LRU_TIEBREAK_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LFU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfu cache assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define LFU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfu cache assertion failed");

`endif

// File: rtl/lfu_pkg.sv
// Shared types and constants of the LFU cache
package lfu_pkg;

  localparam int          ENTRIES_DEF = 16;
  localparam int          DATA_W      = 32;
  localparam int          STAMP_W     = 64;
  localparam int          CAP_W       = 5;
  localparam logic [4:0]  CAP_RESET   = 5'd16;
  localparam logic        OP_GET      = 1'b0;
  localparam logic        OP_PUT      = 1'b1;
  localparam logic [31:0] CNT_MAX     = 32'hFFFF_FFFF;
  localparam logic [31:0] CNT_ONE     = 32'd1;
  localparam logic [31:0] MISS_VALUE  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [DATA_W-1:0]  key;
    logic [DATA_W-1:0]  value;
    logic [DATA_W-1:0]  count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic              match_f;
    logic              free_f;
    logic              vic_f;
    logic [DATA_W-1:0] match_cnt;
    logic [DATA_W-1:0] match_val;
    logic [DATA_W-1:0] vic_key;
  } scan_res_t;

endpackage

// File: rtl/lfu_entry_mem.sv
// Entry store: one write port, one registered read port
module lfu_entry_mem #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEF,
  parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IW-1:0]   waddr,
  input  lfu_pkg::entry_t wdata,
  input  logic            re,
  input  logic [IW-1:0]   raddr,
  output lfu_pkg::entry_t rdata
);
  import lfu_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lfu_scan.sv
// Scan unit: key match, first free slot and LFU/LRU victim, one entry per cycle while en is high
module lfu_scan #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEF,
  parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int OCW     = $clog2(ENTRIES + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  logic                       en,
  input  logic                       ent_valid,
  input  lfu_pkg::entry_t            ent,
  input  logic [IW-1:0]              ent_idx,
  input  logic [lfu_pkg::DATA_W-1:0] key,
  output lfu_pkg::scan_res_t         res,
  output logic [IW-1:0]              match_idx,
  output logic [IW-1:0]              free_idx,
  output logic [IW-1:0]              vic_idx,
  output logic [OCW-1:0]             occ
);
  import lfu_pkg::*;

  scan_res_t          res_r, res_nxt;
  logic [IW-1:0]      match_idx_r, match_idx_nxt;
  logic [IW-1:0]      free_idx_r, free_idx_nxt;
  logic [IW-1:0]      vic_idx_r, vic_idx_nxt;
  logic [OCW-1:0]     occ_r, occ_nxt;
  logic [DATA_W-1:0]  vic_cnt_r, vic_cnt_nxt;
  logic [STAMP_W-1:0] vic_stamp_r, vic_stamp_nxt;
  logic               better;

  // lower count wins, then older stamp; equal keeps the earlier index
  assign better = !res_r.vic_f || (ent.count < vic_cnt_r) ||
                  ((ent.count == vic_cnt_r) && (ent.stamp < vic_stamp_r));

  always_comb begin
    res_nxt       = res_r;
    match_idx_nxt = match_idx_r;
    free_idx_nxt  = free_idx_r;
    vic_idx_nxt   = vic_idx_r;
    occ_nxt       = occ_r;
    vic_cnt_nxt   = vic_cnt_r;
    vic_stamp_nxt = vic_stamp_r;
    if (clr) begin
      res_nxt.match_f = 1'b0;
      res_nxt.free_f  = 1'b0;
      res_nxt.vic_f   = 1'b0;
      res_nxt.vic_key = '0;
      occ_nxt         = '0;
    end else if (en) begin
      if (ent_valid) begin
        occ_nxt = occ_r + OCW'(1);
        if (!res_r.match_f && (ent.key == key)) begin
          res_nxt.match_f   = 1'b1;
          res_nxt.match_cnt = ent.count;
          res_nxt.match_val = ent.value;
          match_idx_nxt     = ent_idx;
        end
        if (better) begin
          res_nxt.vic_f   = 1'b1;
          res_nxt.vic_key = ent.key;
          vic_idx_nxt     = ent_idx;
          vic_cnt_nxt     = ent.count;
          vic_stamp_nxt   = ent.stamp;
        end
      end else if (!res_r.free_f) begin
        res_nxt.free_f = 1'b1;
        free_idx_nxt   = ent_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.match_f <= 1'b0;
      res_r.free_f  <= 1'b0;
      res_r.vic_f   <= 1'b0;
      occ_r         <= '0;
    end else begin
      res_r.match_f <= res_nxt.match_f;
      res_r.free_f  <= res_nxt.free_f;
      res_r.vic_f   <= res_nxt.vic_f;
      occ_r         <= occ_nxt;
    end
    res_r.match_cnt <= res_nxt.match_cnt;
    res_r.match_val <= res_nxt.match_val;
    res_r.vic_key   <= res_nxt.vic_key;
    match_idx_r     <= match_idx_nxt;
    free_idx_r      <= free_idx_nxt;
    vic_idx_r       <= vic_idx_nxt;
    vic_cnt_r       <= vic_cnt_nxt;
    vic_stamp_r     <= vic_stamp_nxt;
  end

  assign res       = res_r;
  assign match_idx = match_idx_r;
  assign free_idx  = free_idx_r;
  assign vic_idx   = vic_idx_r;
  assign occ       = occ_r;

endmodule

// File: rtl/lfu_cache_with_lru_tiebreak.sv
// LFU key-value cache with LRU tie-break: sequencer, valid bits and result register
// Each request (get or put) passes through these steps from acceptance to the next
// acceptance: it is taken, every entry is read from the entry memory
// through its single read port into the scan unit, the last read completes,
// the scan result settles, and a final update state, S_UPD, writes
// back and loads the result register. The result register lets the next
// request be taken while a result waits; the update step holds until the
// result register is free. in_ready is low while a request is in progress, and
// so is cfg_ready. There is no clearing pass after reset.
module lfu_cache_with_lru_tiebreak #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic signed [lfu_pkg::DATA_W-1:0] in_lookup_key,
  input  logic signed [lfu_pkg::DATA_W-1:0] in_write_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic signed [lfu_pkg::DATA_W-1:0] out_read_value,
  output logic                              out_evicted,
  output logic signed [lfu_pkg::DATA_W-1:0] out_evicted_key,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0]         cfg_data
);
  import lfu_pkg::*;

  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCW = $clog2(ENTRIES + 1);
  localparam int CW  = (OCW > CAP_W) ? OCW : CAP_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPD} state_t;

  state_t             state_r, state_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic [STAMP_W-1:0] opctr_r, opctr_nxt;
  logic [OCW-1:0]     idx_r, idx_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic [IW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               op_r, op_nxt;
  logic [DATA_W-1:0]  key_r, key_nxt;
  logic [DATA_W-1:0]  val_r, val_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [DATA_W-1:0]  out_rd_r, out_rd_nxt;
  logic               out_ev_r, out_ev_nxt;
  logic [DATA_W-1:0]  out_evk_r, out_evk_nxt;

  logic               in_acc;
  logic               issue;
  logic               scan_clr;
  logic               out_free;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  entry_t             mem_wdata;
  entry_t             mem_rdata;
  scan_res_t          sres;
  logic [IW-1:0]      match_idx, free_idx, vic_idx;
  logic [OCW-1:0]     occ;
  logic [CW-1:0]      cap_ext, cap_eff;
  logic               evict;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign issue     = (state_r == S_SCAN) && (idx_r != OCW'(ENTRIES));
  assign scan_clr  = in_acc;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cap_ext = CW'(cap_r);
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign evict = (CW'(occ) >= cap_eff) && sres.vic_f;

  lfu_entry_mem #(.ENTRIES(ENTRIES), .IW(IW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (issue),
    .raddr (idx_r[IW-1:0]),
    .rdata (mem_rdata)
  );

  lfu_scan #(.ENTRIES(ENTRIES), .IW(IW), .OCW(OCW)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (scan_clr),
    .en        (rd_pend_r),
    .ent_valid (valid_r[rd_idx_r]),
    .ent       (mem_rdata),
    .ent_idx   (rd_idx_r),
    .key       (key_r),
    .res       (sres),
    .match_idx (match_idx),
    .free_idx  (free_idx),
    .vic_idx   (vic_idx),
    .occ       (occ)
  );

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    cap_nxt       = cap_r;
    opctr_nxt     = opctr_r;
    idx_nxt       = idx_r;
    rd_pend_nxt   = issue;
    rd_idx_nxt    = issue ? idx_r[IW-1:0] : rd_idx_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    stamp_nxt     = stamp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hit_nxt   = out_hit_r;
    out_rd_nxt    = out_rd_r;
    out_ev_nxt    = out_ev_r;
    out_evk_nxt   = out_evk_r;
    mem_we        = 1'b0;
    mem_waddr     = match_idx;
    mem_wdata     = '{key: key_r, value: val_r, count: CNT_ONE, stamp: stamp_r};

    if (cfg_valid && cfg_ready) begin
      cap_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_opcode;
          key_nxt   = in_lookup_key;
          val_nxt   = in_write_value;
          stamp_nxt = opctr_r;
          opctr_nxt = opctr_r + STAMP_W'(1);
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx_nxt = idx_r + OCW'(1);
        end else if (!rd_pend_r) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = sres.match_f;
          out_ev_nxt    = 1'b0;
          out_evk_nxt   = '0;
          out_rd_nxt    = '0;
          if (sres.match_f) begin
            mem_we          = 1'b1;
            mem_waddr       = match_idx;
            mem_wdata.value = (op_r == OP_PUT) ? val_r : sres.match_val;
            mem_wdata.count = (sres.match_cnt == CNT_MAX) ? CNT_MAX :
                              sres.match_cnt + CNT_ONE;
            if (op_r == OP_GET) begin
              out_rd_nxt = sres.match_val;
            end
          end else if (op_r == OP_GET) begin
            out_rd_nxt = MISS_VALUE;
          end else if (evict) begin
            mem_we             = 1'b1;
            mem_waddr          = vic_idx;
            valid_nxt[vic_idx] = 1'b1;
            out_ev_nxt         = 1'b1;
            out_evk_nxt        = sres.vic_key;
          end else if (sres.free_f) begin
            mem_we              = 1'b1;
            mem_waddr           = free_idx;
            valid_nxt[free_idx] = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      cap_r       <= CAP_RESET;
      opctr_r     <= '0;
      idx_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cap_r       <= cap_nxt;
      opctr_r     <= opctr_nxt;
      idx_r       <= idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r  <= rd_idx_nxt;
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    stamp_r   <= stamp_nxt;
    out_hit_r <= out_hit_nxt;
    out_rd_r  <= out_rd_nxt;
    out_ev_r  <= out_ev_nxt;
    out_evk_r <= out_evk_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_rd_r;
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = out_evk_r;

endmodule

// File: rtl/lfu_checker.sv
// Port-level checker for the LFU cache, bound to the top level
`include "lfu_cache_with_lru_tiebreak_macros.svh"

module lfu_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_hit,
  input logic signed [lfu_pkg::DATA_W-1:0] out_read_value,
  input logic                              out_evicted,
  input logic signed [lfu_pkg::DATA_W-1:0] out_evicted_key
);
  import lfu_pkg::*;

  logic                  out_stall;
  logic [2*DATA_W+1:0]   out_payload;

  assign out_stall   = out_valid && !out_ready;
  assign out_payload = {out_hit, out_read_value, out_evicted, out_evicted_key};

  // stalled result holds
  `LFU_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload))
  // an eviction only on a miss
  `LFU_ASSERT_NOW(a_evict_miss, out_valid && out_evicted, !out_hit)
  // no eviction, no evicted key
  `LFU_ASSERT_NOW(a_evk_zero, out_valid && !out_evicted, out_evicted_key == '0)
  // busy once a request is taken
  `LFU_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)

endmodule

bind lfu_cache_with_lru_tiebreak lfu_checker u_lfu_checker (.*);
